FILE: rtl/mkd_pkg.sv
package mkd_pkg;

  // Buffer geometry.
  localparam int unsigned MAX_SYMBOLS = 4;
  localparam int unsigned SYM_IDX_W   = $clog2(MAX_SYMBOLS);
  localparam int unsigned COUNT_W     = $clog2(MAX_SYMBOLS + 1);

  // Field widths.
  localparam int unsigned MS_W     = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd0;
  localparam logic [OP_W-1:0] OP_SPACE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Symbol classes.
  localparam logic [CLASS_W-1:0] CLS_NONE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_DOT     = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_DASH    = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT   = 2'd2;

  // Configuration reset values.
  localparam logic [MS_W-1:0] SHORT_LIMIT_RST = 16'd250;
  localparam logic [MS_W-1:0] LONG_LIMIT_RST  = 16'd1000;
  localparam logic [MS_W-1:0] GAP_LIMIT_RST   = 16'd1000;

  // Character emitted when the held symbols match no letter.
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

  typedef struct packed {
    logic [MS_W-1:0] short_limit;
    logic [MS_W-1:0] long_limit;
    logic [MS_W-1:0] gap_limit;
  } mkd_cfg_t;

  // Held symbols: bit i of pattern is symbol i, 1 for a dash.
  typedef struct packed {
    logic [MAX_SYMBOLS-1:0] pattern;
    logic [COUNT_W-1:0]     count;
  } mkd_state_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [MS_W-1:0] press_ms;
    logic [MS_W-1:0] gap_ms;
  } mkd_item_t;

  typedef struct packed {
    logic                 letter_valid;
    logic [CHAR_W-1:0]    letter;
    logic [CLASS_W-1:0]   symbol_class;
    logic [COUNT_W-1:0]   symbols_held;
  } mkd_result_t;

endpackage

FILE: rtl/mkd_match.sv
module mkd_match
  import mkd_pkg::*;
(
  input  mkd_state_t        held,
  output logic [CHAR_W-1:0] letter
);

  // Table lookup keyed on symbol count and pattern; unused pattern bits are zero.
  always_comb begin
    case ({held.count, held.pattern})
      {3'd2, 4'd2}:  letter = 7'h41; // A
      {3'd4, 4'd1}:  letter = 7'h42; // B
      {3'd4, 4'd5}:  letter = 7'h43; // C
      {3'd3, 4'd1}:  letter = 7'h44; // D
      {3'd1, 4'd0}:  letter = 7'h45; // E
      {3'd4, 4'd4}:  letter = 7'h46; // F
      {3'd3, 4'd3}:  letter = 7'h47; // G
      {3'd4, 4'd0}:  letter = 7'h48; // H
      {3'd2, 4'd0}:  letter = 7'h49; // I
      {3'd4, 4'd14}: letter = 7'h4A; // J
      {3'd3, 4'd5}:  letter = 7'h4B; // K
      {3'd4, 4'd2}:  letter = 7'h4C; // L
      {3'd2, 4'd3}:  letter = 7'h4D; // M
      {3'd2, 4'd1}:  letter = 7'h4E; // N
      {3'd3, 4'd7}:  letter = 7'h4F; // O
      {3'd4, 4'd6}:  letter = 7'h50; // P
      {3'd4, 4'd11}: letter = 7'h51; // Q
      {3'd3, 4'd2}:  letter = 7'h52; // R
      {3'd3, 4'd0}:  letter = 7'h53; // S
      {3'd1, 4'd1}:  letter = 7'h54; // T
      {3'd3, 4'd4}:  letter = 7'h55; // U
      {3'd4, 4'd8}:  letter = 7'h56; // V
      {3'd3, 4'd6}:  letter = 7'h57; // W
      {3'd4, 4'd9}:  letter = 7'h58; // X
      {3'd4, 4'd13}: letter = 7'h59; // Y
      {3'd4, 4'd3}:  letter = 7'h5A; // Z
      default:       letter = CHAR_UNKNOWN;
    endcase
  end

endmodule

FILE: rtl/mkd_step.sv
module mkd_step
  import mkd_pkg::*;
(
  input  mkd_cfg_t    cfg,
  input  mkd_state_t  cur,
  input  mkd_item_t   item,
  output mkd_state_t  nxt,
  output mkd_result_t res
);

  logic [CHAR_W-1:0]    match_letter;
  logic                 flush;
  logic [CLASS_W-1:0]   cls;
  mkd_state_t           base;
  mkd_state_t           appended;

  mkd_match u_match (
    .held   (cur),
    .letter (match_letter)
  );

  // A long gap or a full buffer ends the pending letter before the new symbol.
  assign flush = (item.gap_ms > cfg.gap_limit) ||
                 (cur.count >= COUNT_W'(MAX_SYMBOLS));

  // The long limit is checked first so it wins over the dot test.
  always_comb begin
    if (item.press_ms >= cfg.long_limit) begin
      cls = CLS_INVALID;
    end else if (item.press_ms < cfg.short_limit) begin
      cls = CLS_DOT;
    end else begin
      cls = CLS_DASH;
    end
  end

  // Append a valid symbol to the buffer left after an optional flush.
  always_comb begin
    base     = flush ? '0 : cur;
    appended = base;
    if (cls != CLS_INVALID && base.count < COUNT_W'(MAX_SYMBOLS)) begin
      if (cls == CLS_DASH) begin
        appended.pattern[base.count[SYM_IDX_W-1:0]] = 1'b1;
      end
      appended.count = base.count + COUNT_W'(1);
    end
  end

  // Per-operation next state and result word.
  always_comb begin
    nxt              = cur;
    res.letter_valid = 1'b0;
    res.letter       = '0;
    res.symbol_class = CLS_NONE;
    case (item.operation)
      OP_RELEASE: begin
        nxt              = appended;
        res.letter_valid = flush;
        res.letter       = flush ? match_letter : '0;
        res.symbol_class = cls;
      end
      OP_SPACE: begin
        nxt              = '0;
        res.letter_valid = 1'b1;
        res.letter       = match_letter;
      end
      OP_CLEAR: begin
        nxt = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.symbols_held = nxt.count;
  end

endmodule

FILE: rtl/morse_keypress_decoder.sv
// Channel | Direction | Handshake              | Word
// in_     | input     | in_valid / in_ready    | operation, press_ms, gap_ms
// out_    | output    | out_valid / out_ready  | letter_valid, letter, symbol_class,
//         |           |                        | symbols_held
// cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One word per cycle sustained while the output is not stalled.
// The input register feeds the table match and classifier, whose result and buffer
// update are captured together in the output register and the state registers.
// Reset is synchronous and active low; it clears the buffer and loads the default limits.
// A stalled output holds the word in the input register; in_ready then drops.
module morse_keypress_decoder
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [MS_W-1:0]      in_press_ms,
  input  logic [MS_W-1:0]      in_gap_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_letter_valid,
  output logic [CHAR_W-1:0]    out_letter,
  output logic [CLASS_W-1:0]   out_symbol_class,
  output logic [COUNT_W-1:0]   out_symbols_held,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_wdata
);

  mkd_cfg_t    cfg_r;
  mkd_state_t  state_r;
  mkd_state_t  state_nxt;
  mkd_item_t   item_r;
  logic        item_valid_r;
  mkd_result_t res_r;
  mkd_result_t res_nxt;
  logic        out_valid_r;
  logic        advance;

  // A held word moves on when the output register is empty or being drained.
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_limit <= SHORT_LIMIT_RST;
      cfg_r.long_limit  <= LONG_LIMIT_RST;
      cfg_r.gap_limit   <= GAP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_LIMIT: cfg_r.short_limit <= cfg_wdata;
        CFG_LONG_LIMIT:  cfg_r.long_limit  <= cfg_wdata;
        CFG_GAP_LIMIT:   cfg_r.gap_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation <= in_operation;
      item_r.press_ms  <= in_press_ms;
      item_r.gap_ms    <= in_gap_ms;
    end
  end

  mkd_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Symbol buffer updates together with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_letter_valid = res_r.letter_valid;
  assign out_letter       = res_r.letter;
  assign out_symbol_class = res_r.symbol_class;
  assign out_symbols_held = res_r.symbols_held;

  // The buffer never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= COUNT_W'(MAX_SYMBOLS))
    else $error("symbol count above capacity");

  // A shown result reports the buffer it left behind.
  a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(advance) |-> out_symbols_held == state_r.count)
    else $error("symbols_held disagrees with buffer");

  // No decoded letter means the letter field is zero.
  a_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.letter_valid |-> res_r.letter == '0)
    else $error("letter set without letter_valid");

  // A held word with an empty output register produces a result next cycle.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held word did not reach the output");

endmodule

FILE: tb/morse_checker.sv
module morse_checker
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [MS_W-1:0]      in_press_ms,
  input  logic [MS_W-1:0]      in_gap_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_letter_valid,
  input  logic [CHAR_W-1:0]    out_letter,
  input  logic [CLASS_W-1:0]   out_symbol_class,
  input  logic [COUNT_W-1:0]   out_symbols_held,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_wdata,
  output int unsigned          errors,
  output int unsigned          pending,
  output int unsigned          letters_decoded
);

  // Shadow copy of the limits and of the held symbols.
  mkd_cfg_t    limits;
  mkd_state_t  held;
  mkd_result_t decoded_q[$];

  // Look up the held symbols in the Morse alphabet; anything unmatched is '?'.
  function automatic logic [CHAR_W-1:0] letter_for(input logic [COUNT_W-1:0] n,
                                                   input logic [MAX_SYMBOLS-1:0] p);
    logic [7:0] c;
    c = {1'b0, CHAR_UNKNOWN};
    case (n)
      1: begin
        case (p)
          0: c = "E";
          1: c = "T";
          default: ;
        endcase
      end
      2: begin
        case (p)
          0: c = "I";
          1: c = "N";
          2: c = "A";
          3: c = "M";
          default: ;
        endcase
      end
      3: begin
        case (p)
          0: c = "S";
          1: c = "D";
          2: c = "R";
          3: c = "G";
          4: c = "U";
          5: c = "K";
          6: c = "W";
          7: c = "O";
          default: ;
        endcase
      end
      4: begin
        case (p)
          0:  c = "H";
          1:  c = "B";
          2:  c = "L";
          3:  c = "Z";
          4:  c = "F";
          5:  c = "C";
          6:  c = "P";
          8:  c = "V";
          9:  c = "X";
          11: c = "Q";
          13: c = "Y";
          14: c = "J";
          default: ;
        endcase
      end
      default: ;
    endcase
    return c[CHAR_W-1:0];
  endfunction

  // Work out the result of one word and advance the held symbols.
  function automatic mkd_result_t decode_word(input logic [OP_W-1:0] op,
                                              input logic [MS_W-1:0] press,
                                              input logic [MS_W-1:0] gap);
    mkd_result_t r;
    r = '0;
    case (op)
      OP_RELEASE: begin
        // A long gap or a full buffer closes the pending letter first.
        if (gap > limits.gap_limit || held.count >= MAX_SYMBOLS) begin
          r.letter_valid = 1'b1;
          r.letter       = letter_for(held.count, held.pattern);
          held           = '0;
        end
        // The long limit wins even when it lies below the short limit.
        if (press >= limits.long_limit) begin
          r.symbol_class = CLS_INVALID;
        end else if (press < limits.short_limit) begin
          r.symbol_class = CLS_DOT;
        end else begin
          r.symbol_class = CLS_DASH;
        end
        if (r.symbol_class != CLS_INVALID && held.count < MAX_SYMBOLS) begin
          if (r.symbol_class == CLS_DASH) begin
            held.pattern[held.count[SYM_IDX_W-1:0]] = 1'b1;
          end
          held.count = held.count + 1'b1;
        end
      end
      OP_SPACE: begin
        r.letter_valid = 1'b1;
        r.letter       = letter_for(held.count, held.pattern);
        held           = '0;
      end
      OP_CLEAR: begin
        held = '0;
      end
      default: ;
    endcase
    r.symbols_held = held.count;
    return r;
  endfunction

  // Track limit writes, predict accepted words and compare returned words.
  always @(posedge clk) begin
    mkd_result_t want;
    if (!rst_n) begin
      limits.short_limit = SHORT_LIMIT_RST;
      limits.long_limit  = LONG_LIMIT_RST;
      limits.gap_limit   = GAP_LIMIT_RST;
      held               = '0;
      decoded_q.delete();
      errors             = 0;
      letters_decoded    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT_LIMIT: limits.short_limit = cfg_wdata;
          CFG_LONG_LIMIT:  limits.long_limit  = cfg_wdata;
          CFG_GAP_LIMIT:   limits.gap_limit   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = decode_word(in_operation, in_press_ms, in_gap_ms);
        if (want.letter_valid) begin
          letters_decoded++;
        end
        decoded_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_letter_valid !== want.letter_valid) begin
            $error("letter_valid: expected %0d, got %0d", want.letter_valid,
                   out_letter_valid);
            errors++;
          end
          if (out_letter !== want.letter) begin
            $error("letter: expected %0h, got %0h", want.letter, out_letter);
            errors++;
          end
          if (out_symbol_class !== want.symbol_class) begin
            $error("symbol_class: expected %0d, got %0d", want.symbol_class,
                   out_symbol_class);
            errors++;
          end
          if (out_symbols_held !== want.symbols_held) begin
            $error("symbols_held: expected %0d, got %0d", want.symbols_held,
                   out_symbols_held);
            errors++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import mkd_pkg::*;

  // The one operation code the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASE_WORDS = 155;
  localparam int unsigned LONG_HOLD   = 60;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation;
  logic [MS_W-1:0]      in_press_ms;
  logic [MS_W-1:0]      in_gap_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_letter_valid;
  logic [CHAR_W-1:0]    out_letter;
  logic [CLASS_W-1:0]   out_symbol_class;
  logic [COUNT_W-1:0]   out_symbols_held;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MS_W-1:0]      cfg_wdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned letters_decoded;

  // Stimulus controls; idling and hold_requests are shared with the receiver.
  logic        idling;
  int unsigned hold_requests;
  int unsigned words_sent;
  int unsigned settings_run;
  int unsigned lim_short;
  int unsigned lim_long;
  int unsigned lim_gap;

  always #2 clk = ~clk;

  morse_keypress_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_press_ms      (in_press_ms),
    .in_gap_ms        (in_gap_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter_valid (out_letter_valid),
    .out_letter       (out_letter),
    .out_symbol_class (out_symbol_class),
    .out_symbols_held (out_symbols_held),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  morse_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_press_ms      (in_press_ms),
    .in_gap_ms        (in_gap_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter_valid (out_letter_valid),
    .out_letter       (out_letter),
    .out_symbol_class (out_symbol_class),
    .out_symbols_held (out_symbols_held),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .errors           (errors),
    .pending          (pending),
    .letters_decoded  (letters_decoded)
  );

  // Watchdog for a hung handshake.
  initial begin
    #1600000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall bursts while idling, plus long holds on request to back up the block.
  initial begin : receiver
    int unsigned holds_done;
    int unsigned stall;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one word, with an occasional idle burst ahead of it while idling. Called at a falling edge.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [MS_W-1:0] press,
                           input logic [MS_W-1:0] gap);
    int unsigned idle_cycles;
    if (idling && $urandom_range(0, 5) == 0) begin
      idle_cycles = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_press_ms  <= press;
    in_gap_ms    <= gap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) begin
      words_sent++;
    end
  endtask

  // Value in [lo, hi], or anything at all when the range is empty.
  function automatic int unsigned pick(input int lo, input int hi);
    if (lo > hi) begin
      return $urandom_range(0, 65535);
    end
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [MS_W-1:0] dot_press();
    int lowest;
    lowest = (lim_short < lim_long) ? lim_short : lim_long;
    return MS_W'(pick(0, lowest - 1));
  endfunction

  function automatic logic [MS_W-1:0] dash_press();
    return MS_W'(pick(lim_short, lim_long - 1));
  endfunction

  function automatic logic [MS_W-1:0] bad_press();
    return MS_W'(pick(lim_long, 65535));
  endfunction

  function automatic logic [MS_W-1:0] short_gap();
    return MS_W'(pick(0, lim_gap));
  endfunction

  function automatic logic [MS_W-1:0] long_gap();
    return MS_W'(pick(lim_gap + 1, 65535));
  endfunction

  // One letter's worth of presses with random content, then a random way to end it.
  task automatic send_letter();
    int unsigned n_sym;
    int unsigned k;
    n_sym = $urandom_range(0, 5);
    for (k = 0; k < n_sym; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(OP_RELEASE, bad_press(), short_gap());
      end
      send_word(OP_RELEASE, $urandom_range(0, 1) ? dash_press() : dot_press(),
                (k == 0) ? long_gap() : short_gap());
    end
    case ($urandom_range(0, 9))
      0: send_word(OP_CLEAR, MS_W'($urandom_range(0, 65535)),
                   MS_W'($urandom_range(0, 65535)));
      1, 2, 3, 4, 5: send_word(OP_SPACE, MS_W'($urandom_range(0, 65535)), 0);
      default: ;
    endcase
  endtask

  // Mostly well-formed letters, the rest arbitrary words of any operation.
  task automatic send_mix(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(OP_W'($urandom_range(0, 3)), MS_W'($urandom_range(0, 65535)),
                  MS_W'($urandom_range(0, 65535)));
      end else begin
        send_letter();
      end
    end
  endtask

  // Let every result come back, then load all three limits.
  task automatic load_limits(input int unsigned s, input int unsigned l,
                             input int unsigned g);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHORT_LIMIT;
    cfg_wdata <= MS_W'(s);
    @(negedge clk);
    cfg_index <= CFG_LONG_LIMIT;
    cfg_wdata <= MS_W'(l);
    @(negedge clk);
    cfg_index <= CFG_GAP_LIMIT;
    cfg_wdata <= MS_W'(g);
    @(negedge clk);
    cfg_we    <= 1'b0;
    lim_short = s;
    lim_long  = l;
    lim_gap   = g;
    settings_run++;
  endtask

  initial begin : stimulus
    int unsigned s;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_RELEASE;
    in_press_ms   = '0;
    in_gap_ms     = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SHORT_LIMIT;
    cfg_wdata     = '0;
    idling        = 1'b1;
    hold_requests = 0;
    words_sent    = 0;
    settings_run  = 1;
    lim_short     = SHORT_LIMIT_RST;
    lim_long      = LONG_LIMIT_RST;
    lim_gap       = GAP_LIMIT_RST;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset limits (250 / 1000 / 1000).
    send_word(OP_SPACE, 0, 0);                 // empty buffer decodes to '?'
    send_word(OP_RELEASE, 0, 0);               // shortest dot
    send_word(OP_RELEASE, 249, 1000);          // gap equal to the limit keeps the letter
    send_word(OP_RELEASE, 250, 0);             // press exactly at short limit is a dash
    send_word(OP_RELEASE, 999, 0);             // longest dash, buffer now full
    send_word(OP_RELEASE, 1000, 0);            // full buffer decodes, press too long
    send_word(OP_RELEASE, 65535, 65535);       // gap over limit on empty buffer
    send_word(OP_RELEASE, 100, 0);
    send_word(OP_RELEASE, 300, 1001);          // gap just over limit ends the E
    send_word(OP_SPACE, 65535, 65535);         // space ignores its fields
    send_word(OP_RELEASE, 100, 0);
    send_word(OP_CLEAR, 65535, 65535);         // clear drops the pending dot
    send_word(OP_UNUSED, 65535, 65535);        // ignored operation
    send_word(OP_RELEASE, 500, 0);
    send_word(OP_RELEASE, 500, 0);
    send_word(OP_RELEASE, 500, 0);
    send_word(OP_RELEASE, 500, 0);             // four dashes match nothing
    send_word(OP_RELEASE, 10, 0);              // full buffer decodes to '?'
    send_word(OP_SPACE, 0, 0);                 // E
    send_word(OP_RELEASE, 10, 0);
    send_word(OP_RELEASE, 10, 0);
    send_word(OP_RELEASE, 10, 0);
    send_word(OP_RELEASE, 10, 0);
    send_word(OP_SPACE, 0, 0);                 // H

    // Random phases under a range of limit settings.
    hold_requests++;
    send_mix(PHASE_WORDS);
    load_limits(0, 0, 0);
    send_mix(PHASE_WORDS / 2);
    load_limits(65535, 65535, 65535);
    hold_requests++;
    send_mix(PHASE_WORDS);
    load_limits(600, 200, 300);
    send_mix(PHASE_WORDS);
    load_limits(1, 65535, 0);
    send_mix(PHASE_WORDS);
    s = $urandom_range(50, 400);
    load_limits(s, s + $urandom_range(1, 2000), $urandom_range(100, 3000));
    send_mix(PHASE_WORDS);
    load_limits(65535, 0, 65534);
    send_mix(PHASE_WORDS / 2);

    // Closing stretch at full rate on both sides.
    load_limits(SHORT_LIMIT_RST, LONG_LIMIT_RST, GAP_LIMIT_RST);
    idling = 1'b0;
    send_mix(PHASE_WORDS);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Sent %0d key words under %0d limit settings; %0d letters came back decoded.",
             words_sent, settings_run, letters_decoded);
    $display("Receiver held off %0d times for %0d cycles to fill the pipeline.",
             hold_requests, LONG_HOLD);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
